### rtl/chained_hash_insert_search_assert.svh
// ----------------------------------------------------------------------------
// Chained hash table - assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_INSERT_SEARCH_ASSERT_SVH
`define CHAINED_HASH_INSERT_SEARCH_ASSERT_SVH

// check on every rising edge, switched off while reset is high
`define CHIS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every rising edge, reset cycles included
`define CHIS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/chis_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash table - package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package chis_pkg;

   localparam int BUCKETS_DEF = 7;
   localparam int NODES_DEF   = 64;

   localparam int KEY_W     = 31;
   localparam int IDX_OUT_W = 6;

   // key mod BUCKETS: remainder folded MSB first, several bits a cycle
   localparam int MOD_DIGITS = 8;
   localparam int MOD_STEPS  = (KEY_W + MOD_DIGITS - 1) / MOD_DIGITS;
   localparam int MOD_W      = MOD_STEPS * MOD_DIGITS;
   localparam int MOD_CNT_W  = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

   localparam logic ACT_INSERT = 1'b0;

   typedef enum logic [1:0] {
      RES_OK   = 2'd0,
      RES_MISS = 2'd1,
      RES_FULL = 2'd2
   } res_code_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_HEAD,
      ST_DECIDE,
      ST_WALK,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic         clear_step;
      logic         load_req;
      logic         mod_step;
      logic         head_read;
      logic         ins_commit;
      logic         node_read_head;
      logic         node_read_link;
      logic         res_set;
      res_code_type res_code;
      logic         res_from_pool;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic mod_done;
      logic is_search;
      logic head_valid;
      logic pool_full;
      logic key_match;
      logic link_valid;
      logic rsp_free;
   } dp_status_type;

endpackage

### rtl/chis_ram.sv
// ----------------------------------------------------------------------------
// Chained hash table - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module chis_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/chis_ctrl.sv
// ----------------------------------------------------------------------------
// Chained hash table - controller
// Sequences clearing, bucket reduction, head lookup, insert and chain walk.
// ----------------------------------------------------------------------------
module chis_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  chis_pkg::dp_status_type sts,
   output chis_pkg::cmd_type      cmd
);

   chis_pkg::state_type state_ff;
   chis_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chis_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         chis_pkg::ST_CLEAR: begin
            if (sts.clear_done) state_in = chis_pkg::ST_IDLE;
         end
         chis_pkg::ST_IDLE: begin
            if (req_valid) state_in = chis_pkg::ST_MOD;
         end
         chis_pkg::ST_MOD: begin
            if (sts.mod_done) state_in = chis_pkg::ST_HEAD;
         end
         chis_pkg::ST_HEAD: begin
            state_in = chis_pkg::ST_DECIDE;
         end
         chis_pkg::ST_DECIDE: begin
            if (sts.is_search && sts.head_valid) begin
               state_in = chis_pkg::ST_WALK;
            end else begin
               state_in = chis_pkg::ST_REPLY;
            end
         end
         chis_pkg::ST_WALK: begin
            if (sts.key_match || !sts.link_valid) state_in = chis_pkg::ST_REPLY;
         end
         chis_pkg::ST_REPLY: begin
            if (sts.rsp_free) state_in = chis_pkg::ST_IDLE;
         end
         default: begin
            state_in = chis_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.res_code = chis_pkg::RES_OK;
      req_stall    = 1'b1;
      unique case (state_ff)
         chis_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         chis_pkg::ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         chis_pkg::ST_MOD: begin
            cmd.mod_step = 1'b1;
         end
         chis_pkg::ST_HEAD: begin
            cmd.head_read = 1'b1;
         end
         chis_pkg::ST_DECIDE: begin
            priority if (!sts.is_search && sts.pool_full) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = chis_pkg::RES_FULL;
            end else if (!sts.is_search) begin
               cmd.ins_commit    = 1'b1;
               cmd.res_set       = 1'b1;
               cmd.res_code      = chis_pkg::RES_OK;
               cmd.res_from_pool = 1'b1;
            end else if (sts.head_valid) begin
               cmd.node_read_head = 1'b1;
            end else begin
               cmd.res_set  = 1'b1;
               cmd.res_code = chis_pkg::RES_MISS;
            end
         end
         chis_pkg::ST_WALK: begin
            priority if (sts.key_match) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = chis_pkg::RES_OK;
            end else if (sts.link_valid) begin
               cmd.node_read_link = 1'b1;
            end else begin
               cmd.res_set  = 1'b1;
               cmd.res_code = chis_pkg::RES_MISS;
            end
         end
         chis_pkg::ST_REPLY: begin
            cmd.rsp_load = sts.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### rtl/chis_dpath.sv
// ----------------------------------------------------------------------------
// Chained hash table - datapath
// Bucket remainder, head and node memories, pool count, result register.
// ----------------------------------------------------------------------------
module chis_dpath #(
   parameter int BUCKETS = chis_pkg::BUCKETS_DEF,
   parameter int NODES   = chis_pkg::NODES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  chis_pkg::cmd_type             cmd,
   output chis_pkg::dp_status_type       sts,
   input  logic                          req_action,
   input  logic [chis_pkg::KEY_W-1:0]    req_key,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [chis_pkg::IDX_OUT_W-1:0] rsp_node_index
);

   localparam int IW     = $clog2(NODES);
   localparam int CW     = $clog2(NODES + 1);
   localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int RW     = $clog2(BUCKETS) + 1;
   localparam int RW1    = RW + 1;
   localparam int XW     = (IW > chis_pkg::IDX_OUT_W) ? IW : chis_pkg::IDX_OUT_W;
   localparam int HEAD_W = IW + 1;
   localparam int NODE_W = chis_pkg::KEY_W + 1 + IW;

   logic                                act_ff;
   logic [chis_pkg::KEY_W-1:0]          key_ff;
   logic [chis_pkg::MOD_W-1:0]          shift_ff;
   logic [RW-1:0]                       rem_ff;
   logic [chis_pkg::MOD_CNT_W-1:0]      mod_cnt_ff;
   logic [BW-1:0]                       clr_ff;
   logic [CW-1:0]                       used_ff;
   logic [IW-1:0]                       cur_ff;
   chis_pkg::res_code_type              res_code_ff;
   logic [chis_pkg::IDX_OUT_W-1:0]      res_index_ff;
   logic                                rsp_valid_ff;
   chis_pkg::res_code_type              rsp_status_ff;
   logic [chis_pkg::IDX_OUT_W-1:0]      rsp_index_ff;

   logic [RW-1:0]  rem_step;
   logic [RW1-1:0] mod_t;
   logic [BW-1:0]  bucket;

   logic              head_wr_en;
   logic [BW-1:0]     head_wr_addr;
   logic [HEAD_W-1:0] head_wr_data;
   logic [HEAD_W-1:0] head_rd;
   logic [NODE_W-1:0] node_rd;
   logic              node_rd_en;
   logic [IW-1:0]     node_rd_addr;
   logic [XW-1:0]     res_idx_wide;

   // fold MOD_DIGITS key bits into the remainder, one compare-subtract each
   always_comb begin
      rem_step = rem_ff;
      mod_t    = '0;
      for (int i = 0; i < chis_pkg::MOD_DIGITS; i++) begin
         mod_t = {rem_step, shift_ff[chis_pkg::MOD_W-1-i]};
         if (mod_t >= RW1'(BUCKETS)) mod_t = mod_t - RW1'(BUCKETS);
         rem_step = mod_t[RW-1:0];
      end
   end

   assign bucket = rem_ff[BW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff   <= req_action;
         key_ff   <= req_key;
         shift_ff <= chis_pkg::MOD_W'(req_key);
         rem_ff   <= '0;
      end else if (cmd.mod_step) begin
         shift_ff <= shift_ff << chis_pkg::MOD_DIGITS;
         rem_ff   <= rem_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_cnt_ff <= '0;
      end else if (cmd.load_req) begin
         mod_cnt_ff <= '0;
      end else if (cmd.mod_step) begin
         mod_cnt_ff <= mod_cnt_ff + chis_pkg::MOD_CNT_W'(1);
      end
   end

   // sweep the head table once after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step && clr_ff != BW'(BUCKETS - 1)) begin
         clr_ff <= clr_ff + BW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.ins_commit) begin
         used_ff <= used_ff + CW'(1);
      end
   end

   assign head_wr_en   = cmd.clear_step | cmd.ins_commit;
   assign head_wr_addr = cmd.clear_step ? clr_ff : bucket;
   assign head_wr_data = cmd.clear_step ? '0 : {1'b1, used_ff[IW-1:0]};

   chis_ram #(
      .WIDTH (HEAD_W),
      .DEPTH (BUCKETS)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data),
      .rd_en   (cmd.head_read),
      .rd_addr (bucket),
      .rd_data (head_rd)
   );

   assign node_rd_en   = cmd.node_read_head | cmd.node_read_link;
   assign node_rd_addr = cmd.node_read_link ? node_rd[IW-1:0] : head_rd[IW-1:0];

   chis_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (cmd.ins_commit),
      .wr_addr (used_ff[IW-1:0]),
      .wr_data ({key_ff, head_rd}),
      .rd_en   (node_rd_en),
      .rd_addr (node_rd_addr),
      .rd_data (node_rd)
   );

   always_ff @(posedge clock) begin
      if (node_rd_en) cur_ff <= node_rd_addr;
   end

   assign res_idx_wide = cmd.res_from_pool ? XW'(used_ff[IW-1:0]) : XW'(cur_ff);

   always_ff @(posedge clock) begin
      if (cmd.res_set) begin
         res_code_ff  <= cmd.res_code;
         res_index_ff <= (cmd.res_code == chis_pkg::RES_OK) ?
                         res_idx_wide[chis_pkg::IDX_OUT_W-1:0] : '0;
      end
   end

   // output register: hold while stalled, drop once the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_code_ff;
         rsp_index_ff  <= res_index_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_node_index = rsp_index_ff;

   assign sts.clear_done = (clr_ff == BW'(BUCKETS - 1));
   assign sts.mod_done   = (mod_cnt_ff == chis_pkg::MOD_CNT_W'(chis_pkg::MOD_STEPS - 1));
   assign sts.is_search  = (act_ff != chis_pkg::ACT_INSERT);
   assign sts.head_valid = head_rd[IW];
   assign sts.pool_full  = (used_ff == CW'(NODES));
   assign sts.key_match  = (node_rd[NODE_W-1 -: chis_pkg::KEY_W] == key_ff);
   assign sts.link_valid = node_rd[IW];
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;

endmodule

### rtl/chained_hash_insert_search.sv
// ----------------------------------------------------------------------------
// Chained hash table - top level
// Insert and search over a bounded node pool with one chain per bucket.
// ----------------------------------------------------------------------------
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_action, req_key
//   rsp      out        rsp_valid/rsp_stall   rsp_status, rsp_node_index
//
// One item at a time: a search walks its bucket's chain after the head lookup,
// one node memory read per chain node visited.
// The key is reduced modulo BUCKETS first, eight key bits a cycle.
// After reset the head table is swept clear, bucket by bucket; req_stall is
// high meanwhile. A stalled response holds in the output register while the
// next request is accepted and worked on.
// ----------------------------------------------------------------------------
module chained_hash_insert_search #(
   parameter int BUCKETS = chis_pkg::BUCKETS_DEF,
   parameter int NODES   = chis_pkg::NODES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic [chis_pkg::KEY_W-1:0]     req_key,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [chis_pkg::IDX_OUT_W-1:0] rsp_node_index
);

   chis_pkg::cmd_type       cmd;
   chis_pkg::dp_status_type sts;

   chis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   chis_dpath #(
      .BUCKETS (BUCKETS),
      .NODES   (NODES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_action     (req_action),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_node_index (rsp_node_index)
   );

endmodule

### rtl/chis_checker.sv
// ----------------------------------------------------------------------------
// Chained hash table - port checker
// Watches the top-level ports and flags behaviour outside the contract.
// ----------------------------------------------------------------------------
`include "chained_hash_insert_search_assert.svh"

module chis_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [1:0]                     rsp_status,
   input logic [chis_pkg::IDX_OUT_W-1:0] rsp_node_index
);

   // a stalled response beat keeps its payload
   `CHIS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_node_index), "rsp beat changed while stalled")

   // one request in flight: the beat after an accept is stalled
   `CHIS_ASSERT(a_one_in_flight, clock, reset, req_valid && !req_stall |=> req_stall, "second request accepted while busy")

   // head table sweep keeps requests out straight after reset
   `CHIS_ASSERT_ALWAYS(a_clear_after_reset, clock, $fell(reset) |-> req_stall, "request taken during head sweep")

   // a miss or a refused insert carries node index zero
   `CHIS_ASSERT(a_idx_zero, clock, reset, rsp_valid && (rsp_status == chis_pkg::RES_MISS || rsp_status == chis_pkg::RES_FULL) |-> rsp_node_index == '0, "non-zero index on miss or full")

endmodule

bind chained_hash_insert_search chis_checker u_chis_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_node_index (rsp_node_index)
);
